FILE: design/deadline_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the deadline priority queue
// ----------------------------------------------------------------------------
`ifndef DEADLINE_PRIORITY_QUEUE_ASSERT_SVH
`define DEADLINE_PRIORITY_QUEUE_ASSERT_SVH

// hold a condition at every edge outside reset
`define DPQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// condition in one cycle implies the outcome in the next
`define DPQ_ASSERT_NEXT(label, clk, rst, cond, outcome, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (outcome)) \
      else $error(msg);

`endif

FILE: design/dpq_pkg.sv
// ----------------------------------------------------------------------------
// dpq_pkg
// Types, constants and helpers shared by the deadline priority queue.
// ----------------------------------------------------------------------------
package dpq_pkg;

   localparam int unsigned MIN_YEAR           = 2023;
   localparam int unsigned MAX_DAY            = 31;
   localparam int unsigned MAX_MONTH          = 12;
   localparam int unsigned MAX_DIFFICULTY     = 10;
   localparam int unsigned POINTS_PER_SUBTASK = 2;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_BADDATE = 2'd3
   } status_type;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_REMOVE = 1'b1
   } action_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [3:0]  count;
   } entry_type;

   function automatic logic [3:0] difficulty_of(input logic [3:0] count);
      logic [4:0] points;
      points = 5'(count) * 5'(POINTS_PER_SUBTASK);
      if (count == 4'd0) begin
         return 4'd1;
      end else if (points > 5'(MAX_DIFFICULTY)) begin
         return 4'(MAX_DIFFICULTY);
      end else begin
         return points[3:0];
      end
   endfunction

   function automatic logic [22:0] date_key(input entry_type e);
      return {e.year, e.month, e.day};
   endfunction

endpackage

FILE: design/dpq_req_if.sv
// ----------------------------------------------------------------------------
// dpq_req_if
// Request channel of the deadline priority queue.
// ----------------------------------------------------------------------------
interface dpq_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] task_tag;
   logic [4:0]  deadline_day;
   logic [3:0]  deadline_month;
   logic [13:0] deadline_year;
   logic [3:0]  subtask_count;

   modport source (
      output valid, action, task_tag, deadline_day, deadline_month,
             deadline_year, subtask_count,
      input  ready
   );

   modport sink (
      input  valid, action, task_tag, deadline_day, deadline_month,
             deadline_year, subtask_count,
      output ready
   );
endinterface

FILE: design/dpq_rsp_if.sv
// ----------------------------------------------------------------------------
// dpq_rsp_if
// Response channel of the deadline priority queue.
// ----------------------------------------------------------------------------
interface dpq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] out_tag;
   logic [4:0]  out_day;
   logic [3:0]  out_month;
   logic [13:0] out_year;
   logic [3:0]  out_difficulty;
   logic [7:0]  occupancy;

   modport source (
      output valid, status, out_tag, out_day, out_month, out_year,
             out_difficulty, occupancy,
      input  ready
   );

   modport sink (
      input  valid, status, out_tag, out_day, out_month, out_year,
             out_difficulty, occupancy,
      output ready
   );
endinterface

FILE: design/dpq_store.sv
// ----------------------------------------------------------------------------
// dpq_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dpq_store
   import dpq_pkg::*;
#(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic          clock,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/deadline_priority_queue.sv
// ----------------------------------------------------------------------------
// deadline_priority_queue
// Sorted queue of task entries, earliest deadline at the head.
//
// A request on req_port either inserts a task (action 0) or removes the head
// task (action 1); each request gives exactly one response on rsp_port.
// Entries sit in a circular buffer in one memory, kept in deadline order.
// An insert walks back from the tail, one memory read and one shift per cycle,
// until its place is found. A rejected insert, an insert into an empty queue
// and a remove from an empty queue are answered from idle; any other remove
// reads the head entry. The response is registered and shows in the cycle
// after the work ends. One request is handled at a time; a new request is taken
// while the previous response waits only if the sink takes that response in
// the same cycle. A stalled sink holds the response and blocks new requests.
// Reset empties the queue at once; memory contents need no clearing.
// ----------------------------------------------------------------------------
module deadline_priority_queue
   import dpq_pkg::*;
#(
   parameter int QUEUE_DEPTH  = 128,
   parameter int MAX_SUBTASKS = 10
) (
   input  logic       clock,
   input  logic       reset,
   dpq_req_if.sink    req_port,
   dpq_rsp_if.source  rsp_port
);

`include "deadline_priority_queue_assert.svh"

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_INS,
      S_POP
   } state_type;

   function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
      return (idx == LAST) ? '0 : AW'(idx + 1'b1);
   endfunction

   function automatic logic [AW-1:0] prev_idx(input logic [AW-1:0] idx);
      return (idx == '0) ? LAST : AW'(idx - 1'b1);
   endfunction

   state_type     state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] left_ff, left_in;
   entry_type     new_ff, new_in;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   entry_type     rsp_entry_ff, rsp_entry_in;
   logic [3:0]    rsp_diff_ff, rsp_diff_in;
   logic [7:0]    rsp_occ_ff, rsp_occ_in;

   logic [AW-1:0] rd_addr;
   entry_type     rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;

   entry_type     req_entry;
   logic          date_ok;
   logic          accept;
   logic          ahead;
   logic [CW+7:0] occ_wide;

   dpq_store #(
      .DEPTH (QUEUE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_comb begin
      req_entry.tag   = req_port.task_tag;
      req_entry.day   = req_port.deadline_day;
      req_entry.month = req_port.deadline_month;
      req_entry.year  = req_port.deadline_year;
      req_entry.count = (req_port.subtask_count > 4'(MAX_SUBTASKS))
                        ? 4'(MAX_SUBTASKS) : req_port.subtask_count;
   end

   assign date_ok = (req_entry.day != 5'd0) && (6'(req_entry.day) <= 6'(MAX_DAY)) &&
                    (req_entry.month != 4'd0) && (req_entry.month <= 4'(MAX_MONTH)) &&
                    (req_entry.year >= 14'(MIN_YEAR));

   assign req_port.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_port.ready);
   assign accept         = req_port.valid && req_port.ready;

   assign ahead = (date_key(new_ff) < date_key(rd_data)) ||
                  ((date_key(new_ff) == date_key(rd_data)) &&
                   (difficulty_of(new_ff.count) > difficulty_of(rd_data.count)));

   assign rd_addr = (state_ff == S_IDLE)
                    ? ((req_port.action == ACT_REMOVE) ? head_ff : prev_idx(tail_ff))
                    : prev_idx(prev_idx(pos_ff));

   assign occ_wide = {8'd0, count_in};

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      left_in       = left_ff;
      new_in        = new_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_diff_in   = rsp_diff_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = new_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_entry_in = '0;
               rsp_diff_in  = 4'd0;
               if (req_port.action == ACT_INSERT) begin
                  new_in = req_entry;
                  pos_in = tail_ff;
                  left_in = count_ff;
                  if (!date_ok) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_BADDATE;
                  end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_FULL;
                  end else if (count_ff == '0) begin
                     wr_en         = 1'b1;
                     wr_addr       = tail_ff;
                     wr_data       = req_entry;
                     tail_in       = next_idx(tail_ff);
                     count_in      = CW'(count_ff + 1'b1);
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                  end else begin
                     state_in = S_INS;
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  state_in = S_POP;
               end
            end
         end
         S_INS: begin
            wr_en = 1'b1;
            if ((left_ff != '0) && ahead) begin
               wr_data = rd_data;
               pos_in  = prev_idx(pos_ff);
               left_in = CW'(left_ff - 1'b1);
            end else begin
               wr_data       = new_ff;
               tail_in       = next_idx(tail_ff);
               count_in      = CW'(count_ff + 1'b1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end
         end
         S_POP: begin
            head_in       = next_idx(head_ff);
            count_in      = CW'(count_ff - 1'b1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_entry_in  = rd_data;
            rsp_diff_in   = difficulty_of(rd_data.count);
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_occ_in = rsp_valid_in && !(rsp_valid_ff && !rsp_port.ready)
                   ? occ_wide[7:0] : rsp_occ_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      left_ff       <= left_in;
      new_ff        <= new_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_diff_ff   <= rsp_diff_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.status         = rsp_status_ff;
   assign rsp_port.out_tag        = rsp_entry_ff.tag;
   assign rsp_port.out_day        = rsp_entry_ff.day;
   assign rsp_port.out_month      = rsp_entry_ff.month;
   assign rsp_port.out_year       = rsp_entry_ff.year;
   assign rsp_port.out_difficulty = rsp_diff_ff;
   assign rsp_port.occupancy      = rsp_occ_ff;

   `DPQ_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(QUEUE_DEPTH), "count beyond depth")

   `DPQ_ASSERT_NEXT(a_pop_count, clock, reset, state_ff == S_POP,
      count_ff == CW'($past(count_ff) - 1'b1), "remove did not drop count")

   `DPQ_ASSERT_NEXT(a_bad_date, clock, reset,
      accept && (req_port.action == ACT_INSERT) && !date_ok,
      rsp_port.valid && (rsp_port.status == ST_BADDATE), "bad date not reported")

endmodule

FILE: tb/sv/deadline_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deadline_queue_checker
// Watches both channels of the deadline priority queue. Keeps a shadow copy
// of the sorted task list, predicts the reply to every accepted request and
// compares each accepted reply, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module deadline_queue_checker
   import dpq_pkg::*;
#(
   parameter int QUEUE_DEPTH  = 128,
   parameter int MAX_SUBTASKS = 10
) (
   input  logic clock,
   input  logic reset,
   dpq_req_if   req_mon,
   dpq_rsp_if   rsp_mon,
   output int   pending,
   output int   failures
);

   typedef struct packed {
      status_type  status;
      logic [15:0] tag;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [3:0]  difficulty;
      logic [7:0]  occupancy;
   } task_reply_type;

   entry_type      shadow_queue[$];
   task_reply_type expected_replies[$];
   int             mismatch_count = 0;
   int             reply_index    = 0;

   assign failures = mismatch_count;

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t reply %0d: %s is %0d, predicted %0d", $time, reply_index,
               field, got, want);
      mismatch_count++;
   endtask

   function automatic int unsigned task_weight(input logic [3:0] count);
      int unsigned points;
      if (count == 4'd0) begin
         return 1;
      end
      points = count * POINTS_PER_SUBTASK;
      return (points > MAX_DIFFICULTY) ? MAX_DIFFICULTY : points;
   endfunction

   function automatic bit deadline_valid(input entry_type e);
      return e.day >= 1 && e.day <= MAX_DAY && e.month >= 1 && e.month <= MAX_MONTH &&
             e.year >= MIN_YEAR;
   endfunction

   function automatic bit goes_ahead(input entry_type fresh, input entry_type older);
      logic [22:0] fresh_when;
      logic [22:0] older_when;
      fresh_when = {fresh.year, fresh.month, fresh.day};
      older_when = {older.year, older.month, older.day};
      return fresh_when < older_when ||
             (fresh_when == older_when && task_weight(fresh.count) > task_weight(older.count));
   endfunction

   function automatic task_reply_type apply_request(input action_type act,
                                                    input entry_type item);
      task_reply_type reply;
      int             pos;
      entry_type      head;
      reply = '0;
      if (act == ACT_INSERT) begin
         if (item.count > MAX_SUBTASKS) begin
            item.count = 4'(MAX_SUBTASKS);
         end
         if (!deadline_valid(item)) begin
            reply.status = ST_BADDATE;
         end else if (shadow_queue.size() >= QUEUE_DEPTH) begin
            reply.status = ST_FULL;
         end else begin
            pos = shadow_queue.size();
            while (pos > 0 && goes_ahead(item, shadow_queue[pos-1])) begin
               pos--;
            end
            shadow_queue.insert(pos, item);
            reply.status = ST_OK;
         end
      end else if (shadow_queue.size() == 0) begin
         reply.status = ST_EMPTY;
      end else begin
         head             = shadow_queue.pop_front();
         reply.status     = ST_OK;
         reply.tag        = head.tag;
         reply.day        = head.day;
         reply.month      = head.month;
         reply.year       = head.year;
         reply.difficulty = 4'(task_weight(head.count));
      end
      reply.occupancy = 8'(shadow_queue.size());
      return reply;
   endfunction

   always @(posedge clock) begin
      entry_type      item;
      task_reply_type seen;
      task_reply_type want;
      if (reset) begin
         shadow_queue.delete();
         expected_replies.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            item.tag   = req_mon.task_tag;
            item.day   = req_mon.deadline_day;
            item.month = req_mon.deadline_month;
            item.year  = req_mon.deadline_year;
            item.count = req_mon.subtask_count;
            expected_replies.push_back(apply_request(action_type'(req_mon.action), item));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.status     = status_type'(rsp_mon.status);
            seen.tag        = rsp_mon.out_tag;
            seen.day        = rsp_mon.out_day;
            seen.month      = rsp_mon.out_month;
            seen.year       = rsp_mon.out_year;
            seen.difficulty = rsp_mon.out_difficulty;
            seen.occupancy  = rsp_mon.occupancy;
            if (expected_replies.size() == 0) begin
               report_mismatch("status of reply with no request waiting",
                               32'(seen.status), 32'(ST_OK));
            end else begin
               want = expected_replies.pop_front();
               if (seen.status !== want.status)
                  report_mismatch("status", 32'(seen.status), 32'(want.status));
               if (seen.tag !== want.tag)
                  report_mismatch("out_tag", 32'(seen.tag), 32'(want.tag));
               if (seen.day !== want.day)
                  report_mismatch("out_day", 32'(seen.day), 32'(want.day));
               if (seen.month !== want.month)
                  report_mismatch("out_month", 32'(seen.month), 32'(want.month));
               if (seen.year !== want.year)
                  report_mismatch("out_year", 32'(seen.year), 32'(want.year));
               if (seen.difficulty !== want.difficulty)
                  report_mismatch("out_difficulty", 32'(seen.difficulty),
                                  32'(want.difficulty));
               if (seen.occupancy !== want.occupancy)
                  report_mismatch("occupancy", 32'(seen.occupancy), 32'(want.occupancy));
            end
            reply_index++;
         end
      end
      pending <= expected_replies.size();
   end

endmodule

FILE: tb/sv/tb_deadline_priority_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_deadline_priority_queue
// Drives insert and remove requests into the deadline priority queue: a short
// directed run over bad dates, extreme fields and deadline ties, then random
// fill, mixed and drain phases. The sender idles in bursts, the receiver
// stalls on a rotating pattern; the checker predicts and compares replies.
// ----------------------------------------------------------------------------
module tb_deadline_priority_queue;
   import dpq_pkg::*;

   localparam int          QUEUE_DEPTH  = 128;
   localparam int          MAX_SUBTASKS = 10;
   localparam int          RANDOM_ITEMS = 1925;
   localparam int          DRAIN_CYCLES = 400;
   localparam int unsigned CYCLE_LIMIT  = 1500000;

   logic clock = 1'b0;
   logic reset;
   int   pending;
   int   failures;

   int unsigned burst_left  = 0;
   int unsigned cycle_count = 0;
   logic [15:0] stall_pattern;
   int unsigned pattern_left;

   dpq_req_if req_bus ();
   dpq_rsp_if rsp_bus ();

   deadline_priority_queue #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .MAX_SUBTASKS (MAX_SUBTASKS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   deadline_queue_checker #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .MAX_SUBTASKS (MAX_SUBTASKS)
   ) i_checker (
      .clock    (clock),
      .reset    (reset),
      .req_mon  (req_bus),
      .rsp_mon  (rsp_bus),
      .pending  (pending),
      .failures (failures)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // rotate the stall pattern, reload it now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_pattern <= 16'hFFFF;
         pattern_left  <= 0;
      end else begin
         rsp_bus.ready <= stall_pattern[0];
         if (pattern_left == 0) begin
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h1);
            pattern_left  <= $urandom_range(32, 400);
         end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            pattern_left  <= pattern_left - 1;
         end
      end
   end

   task automatic send_request(input action_type act, input logic [15:0] tag,
                               input logic [4:0] day, input logic [3:0] month,
                               input logic [13:0] year, input logic [3:0] count);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_bus.valid          <= 1'b1;
      req_bus.action         <= act;
      req_bus.task_tag       <= tag;
      req_bus.deadline_day   <= day;
      req_bus.deadline_month <= month;
      req_bus.deadline_year  <= year;
      req_bus.subtask_count  <= count;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic remove_head();
      send_request(ACT_REMOVE, 16'($urandom()), 5'($urandom()), 4'($urandom()),
                   14'($urandom()), 4'($urandom()));
   endtask

   task automatic pick_deadline(output logic [4:0] day, output logic [3:0] month,
                                output logic [13:0] year);
      int unsigned pick;
      pick  = $urandom_range(0, 99);
      day   = 5'($urandom_range(1, 31));
      month = 4'($urandom_range(1, 12));
      year  = 14'($urandom_range(2023, 2099));
      if (pick < 50) begin
         // crowd deadlines together to force ties
         day   = 5'($urandom_range(1, 4));
         month = 4'($urandom_range(1, 2));
         year  = 14'($urandom_range(2023, 2024));
      end else if (pick < 75) begin
      end else if (pick < 85) begin
         year = 14'($urandom_range(2023, 16383));
      end else if (pick < 90) begin
         day = 5'd0;
      end else if (pick < 93) begin
         month = 4'($urandom_range(12, 15));
         if (month == 4'd12) month = 4'd0;
      end else if (pick < 96) begin
         year = 14'($urandom_range(0, 2022));
      end else begin
         day   = 5'($urandom());
         month = 4'($urandom());
         year  = 14'($urandom());
      end
   endtask

   task automatic random_request(input int unsigned insert_pct);
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [3:0]  count;
      pick_deadline(day, month, year);
      count = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 10)) : 4'($urandom());
      if ($urandom_range(1, 100) <= insert_pct) begin
         send_request(ACT_INSERT, 16'($urandom()), day, month, year, count);
      end else begin
         send_request(ACT_REMOVE, 16'($urandom()), day, month, year, count);
      end
   endtask

   initial begin
      int          sent;
      int          seg;
      int          seg_len;
      int unsigned insert_pct;
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.action         <= ACT_INSERT;
      req_bus.task_tag       <= '0;
      req_bus.deadline_day   <= '0;
      req_bus.deadline_month <= '0;
      req_bus.deadline_year  <= '0;
      req_bus.subtask_count  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      remove_head();
      send_request(ACT_INSERT, 16'h0101, 5'd0,  4'd5,  14'd2030,  4'd2);
      send_request(ACT_INSERT, 16'h0102, 5'd10, 4'd0,  14'd2030,  4'd2);
      send_request(ACT_INSERT, 16'h0103, 5'd10, 4'd13, 14'd2030,  4'd2);
      send_request(ACT_INSERT, 16'h0104, 5'd31, 4'd15, 14'd16383, 4'd15);
      send_request(ACT_INSERT, 16'h0105, 5'd28, 4'd12, 14'd2022,  4'd1);
      send_request(ACT_INSERT, 16'h0000, 5'd0,  4'd0,  14'd0,     4'd0);
      send_request(ACT_INSERT, 16'hFFFF, 5'd31, 4'd12, 14'd16383, 4'd15);
      send_request(ACT_INSERT, 16'h0000, 5'd1,  4'd1,  14'd2023,  4'd0);
      send_request(ACT_INSERT, 16'h0201, 5'd1,  4'd1,  14'd2023,  4'd3);
      send_request(ACT_INSERT, 16'h0202, 5'd1,  4'd1,  14'd2023,  4'd3);
      send_request(ACT_INSERT, 16'h0203, 5'd1,  4'd1,  14'd2023,  4'd0);
      send_request(ACT_INSERT, 16'h0301, 5'd15, 4'd6,  14'd2024,  4'd5);
      send_request(ACT_INSERT, 16'h0302, 5'd15, 4'd6,  14'd2024,  4'd11);
      send_request(ACT_INSERT, 16'h0303, 5'd2,  4'd1,  14'd2023,  4'd1);
      send_request(ACT_INSERT, 16'h0304, 5'd1,  4'd1,  14'd10000, 4'd10);
      repeat (10) remove_head();

      sent = 0;
      seg  = 0;
      while (sent < RANDOM_ITEMS) begin
         case (seg % 3)
            0: begin
               insert_pct = 85;
               seg_len    = 320;
            end
            1: begin
               insert_pct = 50;
               seg_len    = 250;
            end
            default: begin
               insert_pct = 15;
               seg_len    = 250;
            end
         endcase
         for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
            random_request(insert_pct);
            sent++;
         end
         seg++;
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/dpq_pkg.sv
design/dpq_req_if.sv
design/dpq_rsp_if.sv
design/dpq_store.sv
design/deadline_priority_queue.sv
tb/sv/deadline_queue_checker.sv
tb/sv/tb_deadline_priority_queue.sv
